@@ hdl/radar_presence_frame_parser_unit_assert.svh @@
// Assertion macros for the radar presence frame parser.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RADAR_PRESENCE_FRAME_PARSER_UNIT_ASSERT_SVH
`define RADAR_PRESENCE_FRAME_PARSER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RPFP_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rpfp check failed");

// Check that a condition implies a consequence in the next cycle.
`define RPFP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpfp sequence check failed");

`endif

@@ hdl/rpfp_pkg.sv @@
// Shared types, constants and byte tables for the radar presence frame parser.
// No dependencies.
`default_nettype none

package rpfp_pkg;

	localparam int MAX_PAYLOAD  = 64;
	localparam int KEEP_BYTES   = 11;
	localparam int MIN_REPORT   = 13;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CAP_IDX_W    = $clog2(KEEP_BYTES);

	localparam logic [7:0] REPORT_TYPE = 8'h02;
	localparam logic [7:0] REPORT_HEAD = 8'hAA;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_BODY   = 3'd3,
		PH_TAIL   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_LEN    = 2'd1,
		ST_BAD_FOOTER = 2'd2,
		ST_NOT_REPORT = 2'd3
	} status_t;

	// One finished frame as handed from the parser to the result stage.
	typedef struct packed {
		status_t     status;
		logic [7:0]  kind_byte;
		logic [15:0] moving_distance;
		logic [7:0]  motion_energy;
		logic [15:0] still_distance;
		logic [7:0]  still_energy;
		logic [15:0] detect_distance;
	} frame_rec_t;

	// Header sequence F4 F3 F2 F1.
	function automatic logic [7:0] head_byte(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'hF4;
			2'd1: v = 8'hF3;
			2'd2: v = 8'hF2;
			2'd3: v = 8'hF1;
			default: v = 8'hF4;
		endcase
		return v;
	endfunction

	// Footer sequence F8 F7 F6 F5.
	function automatic logic [7:0] tail_byte(input logic [1:0] idx);
		logic [7:0] v;
		unique case (idx)
			2'd0: v = 8'hF8;
			2'd1: v = 8'hF7;
			2'd2: v = 8'hF6;
			2'd3: v = 8'hF5;
			default: v = 8'hF8;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ hdl/rpfp_front.sv @@
// Byte-level frame parser: header hunt, length check, payload capture, footer check.
// Depends on rpfp_pkg; pushes one record per finished frame into rpfp_queue.
`default_nettype none

module rpfp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_take,
	input  wire logic [7:0]        rx_byte,
	output logic                   push,
	output rpfp_pkg::frame_rec_t   push_rec
);
	import rpfp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  match_q, match_d;
	logic [7:0]  len_lo_q;
	logic [6:0]  frame_len_q, frame_len_d;
	logic [6:0]  count_q, count_d;
	logic        footer_good_q, footer_good_d;
	logic [7:0]  cap_q [KEEP_BYTES];
	logic        cap_we;
	logic        emit;
	status_t     status;
	logic [6:0]  count_inc;
	logic        tail_ok;

	assign count_inc = count_q + 7'd1;
	assign tail_ok   = footer_good_q && (rx_byte == tail_byte(count_q[1:0]));

	// Next state and result classification for the current byte
	always_comb begin
		phase_d       = phase_q;
		match_d       = match_q;
		frame_len_d   = frame_len_q;
		count_d       = count_q;
		footer_good_d = footer_good_q;
		cap_we        = 1'b0;
		emit          = 1'b0;
		status        = ST_OK;
		unique case (phase_q)
			PH_LEN_LO: begin
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				if ((rx_byte != 8'd0) || (len_lo_q == 8'd0) ||
				    (len_lo_q > 8'(MAX_PAYLOAD))) begin
					phase_d = PH_HUNT;
					match_d = 2'd0;
					emit    = 1'b1;
					status  = ST_BAD_LEN;
				end else begin
					frame_len_d = len_lo_q[6:0];
					count_d     = 7'd0;
					phase_d     = PH_BODY;
				end
			end
			PH_BODY: begin
				cap_we  = (count_q < 7'(KEEP_BYTES));
				count_d = count_inc;
				if (count_inc >= frame_len_q) begin
					count_d       = 7'd0;
					footer_good_d = 1'b1;
					phase_d       = PH_TAIL;
				end
			end
			PH_TAIL: begin
				footer_good_d = tail_ok;
				count_d       = count_inc;
				if (count_inc >= 7'd4) begin
					phase_d = PH_HUNT;
					match_d = 2'd0;
					count_d = 7'd0;
					emit    = 1'b1;
					if (!tail_ok)
						status = ST_BAD_FOOTER;
					else if ((frame_len_q < 7'(MIN_REPORT)) || (cap_q[0] != REPORT_TYPE) ||
					         (cap_q[1] != REPORT_HEAD))
						status = ST_NOT_REPORT;
					else
						status = ST_OK;
				end
			end
			default: begin
				// Header hunt; unused phase codes land here as well
				phase_d = PH_HUNT;
				if (rx_byte == head_byte(match_q)) begin
					if (match_q == 2'd3) begin
						match_d = 2'd0;
						phase_d = PH_LEN_LO;
					end else begin
						match_d = match_q + 2'd1;
					end
				end else begin
					match_d = (rx_byte == head_byte(2'd0)) ? 2'd1 : 2'd0;
				end
			end
		endcase
	end

	// Advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			match_q       <= 2'd0;
			frame_len_q   <= 7'd0;
			count_q       <= 7'd0;
			footer_good_q <= 1'b1;
		end else if (byte_take) begin
			phase_q       <= phase_d;
			match_q       <= match_d;
			frame_len_q   <= frame_len_d;
			count_q       <= count_d;
			footer_good_q <= footer_good_d;
		end
	end

	// Hold the low length byte and the leading payload bytes
	always_ff @(posedge clk) begin
		if (byte_take && (phase_q == PH_LEN_LO))
			len_lo_q <= rx_byte;
		if (byte_take && cap_we)
			cap_q[count_q[CAP_IDX_W-1:0]] <= rx_byte;
	end

	// Build the frame record from the captured payload
	assign push                     = byte_take && emit;
	assign push_rec.status          = status;
	assign push_rec.kind_byte       = cap_q[2];
	assign push_rec.moving_distance = {cap_q[4], cap_q[3]};
	assign push_rec.motion_energy   = cap_q[5];
	assign push_rec.still_distance  = {cap_q[7], cap_q[6]};
	assign push_rec.still_energy    = cap_q[8];
	assign push_rec.detect_distance = {cap_q[10], cap_q[9]};

endmodule

`default_nettype wire

@@ hdl/rpfp_queue.sv @@
// Short record queue between the frame parser and the result stage.
// Depends on rpfp_pkg and the assertion macro header.
`default_nettype none

`include "radar_presence_frame_parser_unit_assert.svh"

module rpfp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rpfp_pkg::frame_rec_t push_rec,
	output logic                   full,
	input  wire logic              pop,
	output logic                   nonempty,
	output rpfp_pkg::frame_rec_t   head_rec
);
	import rpfp_pkg::*;

	frame_rec_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head_rec = entry_q[rd_ptr_q];

	// Entry store, written at the write pointer
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_rec;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	`RPFP_ASSERT(a_no_overflow, clk, arst_n, !(push && full))
	`RPFP_ASSERT(a_no_underflow, clk, arst_n, !(pop && !nonempty))
	`RPFP_ASSERT(a_level_bound, clk, arst_n, count_q <= QCNT_W'(QUEUE_DEPTH))
	`RPFP_ASSERT_NEXT(a_level_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + QCNT_W'(1))

endmodule

`default_nettype wire

@@ hdl/rpfp_back.sv @@
// Result stage: decodes the target report and holds it in the output register.
// Depends on rpfp_pkg; drains records from rpfp_queue.
`default_nettype none

module rpfp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              nonempty,
	input  wire rpfp_pkg::frame_rec_t head_rec,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             frame_status,
	output logic [1:0]             target_kind,
	output logic                   presence,
	output logic                   moving_seen,
	output logic                   stationary_seen,
	output logic [15:0]            moving_distance,
	output logic [7:0]             motion_energy,
	output logic [15:0]            still_distance,
	output logic [7:0]             still_energy,
	output logic [15:0]            detect_distance
);
	import rpfp_pkg::*;

	logic        valid_q;
	logic        good;
	logic [1:0]  kind;

	assign good = (head_rec.status == ST_OK);
	// Target state above 3 decodes as none
	assign kind = (head_rec.kind_byte > 8'd3) ? 2'd0 : head_rec.kind_byte[1:0];
	assign pop  = nonempty && (!valid_q || !out_stall);

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || !out_stall)
			valid_q <= nonempty;
	end

	// Load decoded fields; non-ok results carry zeros
	always_ff @(posedge clk) begin
		if (pop) begin
			frame_status    <= head_rec.status;
			target_kind     <= good ? kind : 2'd0;
			presence        <= good && (kind != 2'd0);
			moving_seen     <= good && kind[0];
			stationary_seen <= good && kind[1];
			moving_distance <= good ? head_rec.moving_distance : 16'd0;
			motion_energy   <= good ? head_rec.motion_energy : 8'd0;
			still_distance  <= good ? head_rec.still_distance : 16'd0;
			still_energy    <= good ? head_rec.still_energy : 8'd0;
			detect_distance <= good ? head_rec.detect_distance : 16'd0;
		end
	end

	assign out_valid = valid_q;

endmodule

`default_nettype wire

@@ hdl/radar_presence_frame_parser_unit.sv @@
// Radar presence frame parser, top level: one received byte per cycle in, one
// result per frame out. A byte is taken every cycle while in_stall is low; the
// parser front end classifies it at once, a finished frame goes into a two-entry
// queue, and the result stage registers the decoded report, so a result passes
// through the queue entry and the output register to out_valid after the last
// footer byte (or second length byte). in_stall rises only when the queue is
// full, which needs two results waiting behind a stalled output.
// Depends on rpfp_pkg, rpfp_front, rpfp_queue and rpfp_back.
`default_nettype none

module radar_presence_frame_parser_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   rx_byte,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [1:0]        frame_status,
	output logic [1:0]        target_kind,
	output logic              presence,
	output logic              moving_seen,
	output logic              stationary_seen,
	output logic [15:0]       moving_distance,
	output logic [7:0]        motion_energy,
	output logic [15:0]       still_distance,
	output logic [7:0]        still_energy,
	output logic [15:0]       detect_distance
);
	import rpfp_pkg::*;

	logic        q_full;
	logic        q_nonempty;
	logic        push;
	logic        pop;
	logic        byte_take;
	frame_rec_t  push_rec;
	frame_rec_t  head_rec;

	// Take a byte whenever the queue has room for a result
	assign in_stall  = q_full;
	assign byte_take = in_valid && !q_full;

	rpfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_take(byte_take),
		.rx_byte  (rx_byte),
		.push     (push),
		.push_rec (push_rec)
	);

	rpfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.full    (q_full),
		.pop     (pop),
		.nonempty(q_nonempty),
		.head_rec(head_rec)
	);

	rpfp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.nonempty       (q_nonempty),
		.head_rec       (head_rec),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_status   (frame_status),
		.target_kind    (target_kind),
		.presence       (presence),
		.moving_seen    (moving_seen),
		.stationary_seen(stationary_seen),
		.moving_distance(moving_distance),
		.motion_energy  (motion_energy),
		.still_distance (still_distance),
		.still_energy   (still_energy),
		.detect_distance(detect_distance)
	);

endmodule

`default_nettype wire
